[hdl/svl_pkg.sv]
// skinned vertex lighting: shared constants and a saturation function
// no dependencies
package svl_pkg;

  localparam int MaxBones  = 64;
  localparam int FracBits  = 16;
  localparam int MatWords  = 12;
  localparam int MemDepth  = MaxBones * MatWords;
  localparam int MemAw     = $clog2(MemDepth);

  localparam logic [1:0] REG_AMB_RED   = 2'd0;
  localparam logic [1:0] REG_AMB_GREEN = 2'd1;
  localparam logic [1:0] REG_AMB_BLUE  = 2'd2;

  localparam logic CMD_MATRIX    = 1'b0;
  localparam logic CMD_INFLUENCE = 1'b1;

  localparam logic signed [47:0] Sum48Max = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] Sum48Min = {1'b1, {47{1'b0}}};

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -50'sh0_8000_0000) return -32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

[hdl/svl_isqrt_div.sv]
// skinned vertex lighting: intensity unit, bit-serial search for the largest k
// with k*k*s <= 65025*ax*ax (0 when nx is not positive), every product on one shared multiplier
// depends on svl_pkg
module svl_intens
  import svl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic signed [31:0] nx,
  input  logic signed [31:0] ny,
  input  logic signed [31:0] nz,
  output logic        done,
  output logic [7:0]  i8
);

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT, S_SQX, S_SQY, S_SQZ, S_RHS, S_TT, S_TTS, S_CMP, S_DONE
  } st_t;

  st_t st_r;
  logic [31:0] ax_r, ay_r, az_r;
  logic [39:0] a2x_r;
  logic [41:0] s_r;
  logic [57:0] rhs_r;
  logic [15:0] tt_r;
  logic [57:0] lhs_r;
  logic [7:0]  k_r, bit_r;
  logic        zero_r;
  logic        done_r;
  logic [7:0]  i8_r;

  assign done = done_r;
  assign i8   = i8_r;

  // shared multiplier
  logic [41:0] ma;
  logic [19:0] mb;
  logic [57:0] mp;
  logic [7:0]  t;
  assign t  = k_r | bit_r;
  assign mp = 58'({20'd0, ma} * {42'd0, mb});

  function automatic logic [31:0] absv(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  always_comb begin
    ma = 42'd0;
    mb = 20'd0;
    case (st_r)
      S_SQX:   begin ma = {22'd0, ax_r[19:0]}; mb = ax_r[19:0]; end
      S_SQY:   begin ma = {22'd0, ay_r[19:0]}; mb = ay_r[19:0]; end
      S_SQZ:   begin ma = {22'd0, az_r[19:0]}; mb = az_r[19:0]; end
      S_RHS:   begin ma = {2'd0, a2x_r};       mb = 20'd65025; end
      S_TT:    begin ma = {34'd0, t};          mb = {12'd0, t}; end
      S_TTS:   begin ma = s_r;                 mb = {4'd0, tt_r}; end
      default: begin ma = 42'd0;               mb = 20'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
      i8_r   <= 8'd0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        S_IDLE: if (start) begin
          ax_r <= absv(nx); ay_r <= absv(ny); az_r <= absv(nz);
          zero_r <= (nx <= 32'sd0);
          st_r <= S_SHIFT;
        end
        S_SHIFT: begin
          if (zero_r) begin
            i8_r <= 8'd0; done_r <= 1'b1; st_r <= S_IDLE;
          end else if (ax_r[31:20] != 0 || ay_r[31:20] != 0 || az_r[31:20] != 0) begin
            ax_r <= ax_r >> 1; ay_r <= ay_r >> 1; az_r <= az_r >> 1;
          end else if (ax_r == 0) begin
            i8_r <= 8'd0; done_r <= 1'b1; st_r <= S_IDLE;
          end else st_r <= S_SQX;
        end
        S_SQX: begin
          a2x_r <= mp[39:0];
          s_r   <= {2'd0, mp[39:0]};
          st_r  <= S_SQY;
        end
        S_SQY: begin
          s_r <= s_r + {2'd0, mp[39:0]};
          st_r <= S_SQZ;
        end
        S_SQZ: begin
          s_r <= s_r + {2'd0, mp[39:0]};
          st_r <= S_RHS;
        end
        S_RHS: begin
          rhs_r <= mp;
          k_r <= 8'd0; bit_r <= 8'd128;
          st_r <= S_TT;
        end
        S_TT:  begin tt_r <= mp[15:0]; st_r <= S_TTS; end
        S_TTS: begin lhs_r <= mp; st_r <= S_CMP; end
        S_CMP: begin
          if (lhs_r <= rhs_r) k_r <= t;
          if (bit_r == 8'd1) st_r <= S_DONE;
          else begin bit_r <= bit_r >> 1; st_r <= S_TT; end
        end
        S_DONE: begin i8_r <= k_r; done_r <= 1'b1; st_r <= S_IDLE; end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/skinned_vertex_lighting.sv]
// skinned vertex lighting top level: bone matrix store, shared multiply-accumulate
// sequencer, output register and configuration port
// depends on svl_pkg and svl_intens
//
// usage: software writes ambient levels over the apb port, then loads bone
// matrices with command 0 requests (one element each, ignored when out of range).
// each vertex arrives as one command 1 request per bone influence; the request
// with last_influence set produces one result on the out_ channel.
// a matrix write leaves in_ready high, so the next request can follow at once.
// an influence holds in_ready low while the single shared 32x32 multiplier does
// its 18 matrix products and 6 weight products in turn behind a registered matrix
// memory read, so the next request is taken only after that work is done.
// the last influence then runs the normal prescale and the 8-step intensity
// search, skipped with intensity 0 when the summed normal does not face the light.
// a finished result waits in the output register while the receiver stalls;
// the block keeps taking requests and only holds the next result, with in_ready
// low, until the waiting one is taken.
// reset clears the accumulators and sets ambient levels to 128; matrix
// contents are undefined until written.
module skinned_vertex_lighting
  import svl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [5:0]  in_bone,
  input  logic [3:0]  in_element,
  input  logic signed [31:0] in_matrix_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  input  logic [15:0] in_weight,
  input  logic        in_last_influence,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_out_x,
  output logic signed [31:0] out_out_y,
  output logic signed [31:0] out_out_z,
  output logic [7:0]  out_color_red,
  output logic [7:0]  out_color_green,
  output logic [7:0]  out_color_blue,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_ACC, S_ROW, S_WP, S_WN, S_NEXT, S_INT, S_OUT, S_EMIT
  } st_t;

  st_t st_r;
  logic [7:0] amb_r_r, amb_g_r, amb_b_r;

  // config port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_AMB_RED:   prdata = {24'd0, amb_r_r};
      REG_AMB_GREEN: prdata = {24'd0, amb_g_r};
      REG_AMB_BLUE:  prdata = {24'd0, amb_b_r};
      default:       prdata = 32'd0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amb_r_r <= 8'd128; amb_g_r <= 8'd128; amb_b_r <= 8'd128;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_AMB_RED:   amb_r_r <= pwdata[7:0];
        REG_AMB_GREEN: amb_g_r <= pwdata[7:0];
        REG_AMB_BLUE:  amb_b_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // matrix memory
  logic signed [31:0] mem [MemDepth];
  logic [MemAw-1:0]   rd_addr;
  logic signed [31:0] rd_q_r;
  logic               in_acc;
  logic [MemAw-1:0]   wr_addr;
  assign in_acc  = in_valid && in_ready;
  assign wr_addr = MemAw'(in_bone * MatWords + in_element);
  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_MATRIX && in_bone < MaxBones && in_element < MatWords)
      mem[wr_addr] <= in_matrix_value;
    rd_q_r <= mem[rd_addr];
  end

  // held request
  logic signed [31:0] pos_r [3];
  logic signed [31:0] nin_r [3];
  logic [5:0]  bone_r;
  logic [15:0] w_r;
  logic        last_r;
  logic [1:0]  row_r, col_r;
  logic        nrm_r; // 0 position term, 1 normal term
  logic signed [49:0] tp_r, tn_r;
  logic signed [47:0] psum_r [3];
  logic signed [31:0] nsum_r [3];

  assign rd_addr = MemAw'(bone_r * MatWords + row_r * 4 + col_r);

  // shared multiplier
  logic signed [31:0] ma, mb;
  logic signed [63:0] mp_r;
  always_comb begin
    ma = rd_q_r;
    mb = nrm_r ? nin_r[col_r] : pos_r[col_r];
    case (st_r)
      S_WP:    begin ma = sat32(tp_r); mb = $signed({16'd0, w_r}); end
      S_WN:    begin ma = sat32(tn_r); mb = $signed({16'd0, w_r}); end
      default: ;
    endcase
  end

  logic       int_start, int_done;
  logic [7:0] i8;
  svl_intens u_int (
    .clk(clk), .rst_n(rst_n), .start(int_start),
    .nx(nsum_r[0]), .ny(nsum_r[1]), .nz(nsum_r[2]),
    .done(int_done), .i8(i8)
  );
  assign int_start = (st_r == S_NEXT) && last_r;

  logic signed [63:0] prod;
  assign prod = 64'(ma) * 64'(mb);
  logic signed [49:0] psh;
  assign psh = 50'(mp_r >>> FracBits);

  function automatic logic [7:0] lit(input logic [7:0] a, input logic [7:0] i);
    logic [8:0] c;
    c = {1'b0, a} + {1'b0, i};
    return c[8] ? 8'hFF : c[7:0];
  endfunction

  logic signed [48:0] padd;
  logic signed [32:0] nadd;
  assign padd = 49'(psum_r[row_r]) + 49'(psh);
  assign nadd = 33'(nsum_r[row_r]) + 33'(psh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      in_ready <= 1'b1;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin psum_r[i] <= '0; nsum_r[i] <= '0; end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: if (in_acc && in_command == CMD_INFLUENCE) begin
          pos_r[0] <= in_pos_x; pos_r[1] <= in_pos_y; pos_r[2] <= in_pos_z;
          nin_r[0] <= 32'(in_norm_x); nin_r[1] <= 32'(in_norm_y);
          nin_r[2] <= 32'(in_norm_z);
          bone_r <= in_bone; w_r <= in_weight; last_r <= in_last_influence;
          row_r <= 2'd0; col_r <= 2'd0; nrm_r <= 1'b0;
          in_ready <= 1'b0;
          st_r <= (in_bone < MaxBones) ? S_RD : S_NEXT;
        end
        S_RD: st_r <= (col_r == 2'd3) ? S_ROW : S_MUL;
        S_MUL: begin mp_r <= prod; st_r <= S_ACC; end
        S_ACC: begin
          if (!nrm_r) begin
            tp_r <= (col_r == 0 ? 50'sd0 : tp_r) + psh;
            nrm_r <= 1'b1;
            st_r <= S_MUL;
          end else begin
            tn_r <= (col_r == 0 ? 50'sd0 : tn_r) + psh;
            nrm_r <= 1'b0;
            col_r <= col_r + 2'd1;
            st_r <= S_RD;
          end
        end
        S_ROW: begin
          // col 3 read is now on rd_q_r: translation
          tp_r <= tp_r + 50'(rd_q_r);
          st_r <= S_WP;
        end
        S_WP: begin mp_r <= prod; st_r <= S_WN; end
        S_WN: begin
          psum_r[row_r] <= (padd > 49'(Sum48Max)) ? Sum48Max :
                           (padd < 49'(Sum48Min)) ? Sum48Min : padd[47:0];
          mp_r <= prod;
          st_r <= S_OUT;
          col_r <= 2'd0;
        end
        S_OUT: begin
          nsum_r[row_r] <= sat32(50'(nadd));
          if (row_r == 2'd2) st_r <= S_NEXT;
          else begin row_r <= row_r + 2'd1; st_r <= S_RD; end
        end
        S_NEXT: begin
          if (last_r) st_r <= S_INT;
          else begin st_r <= S_IDLE; in_ready <= 1'b1; end
        end
        S_INT: if (int_done) st_r <= S_EMIT;
        S_EMIT: if (!out_valid || out_ready) begin
          for (int i = 0; i < 3; i++) begin
            psum_r[i] <= '0; nsum_r[i] <= '0;
          end
          out_out_x <= sat32(50'(psum_r[0]));
          out_out_y <= sat32(50'(psum_r[1]));
          out_out_z <= sat32(50'(psum_r[2]));
          out_color_red   <= lit(amb_r_r, i8);
          out_color_green <= lit(amb_g_r, i8);
          out_color_blue  <= lit(amb_b_r, i8);
          out_valid <= 1'b1;
          in_ready <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/testbench.sv]
// testbench for skinned_vertex_lighting: bone loads, blended vertices and ambient lighting
// predicts every lit vertex in fixed point and checks results against it
// depends on svl_pkg and the skinned_vertex_lighting rtl
`timescale 1ns / 100ps

module testbench
  import svl_pkg::*;
();

  typedef struct packed {
    logic               cmd;
    logic [5:0]         bone;
    logic [3:0]         elem;
    logic signed [31:0] mval;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [15:0]        w;
    logic               last;
  } request_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic [5:0] in_bone = '0;
  logic [3:0] in_element = '0;
  logic signed [31:0] in_matrix_value = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_pos_z = '0;
  logic signed [15:0] in_norm_x = '0;
  logic signed [15:0] in_norm_y = '0;
  logic signed [15:0] in_norm_z = '0;
  logic [15:0] in_weight = '0;
  logic in_last_influence = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_out_x;
  logic signed [31:0] out_out_y;
  logic signed [31:0] out_out_z;
  logic [7:0] out_color_red;
  logic [7:0] out_color_green;
  logic [7:0] out_color_blue;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  skinned_vertex_lighting dut (.*);

  // predictor state
  int          bone_mat [MemDepth];
  logic [11:0] bone_written [MaxBones];
  int          ready_bones [$];
  longint      pos_acc [3];
  longint      nrm_acc [3];
  logic [7:0]  amb_r = 8'd128;
  logic [7:0]  amb_g = 8'd128;
  logic [7:0]  amb_b = 8'd128;

  vertex_t pending_vertices [$];
  int  errors = 0;
  int  cycles = 0;
  int  vertices_seen = 0;
  int  matrix_writes = 0;
  int  influences = 0;
  bit  quiet = 1'b0;
  bit  hold_start = 1'b0;
  int  long_hold = 0;
  int  stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip48(longint v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return v;
  endfunction

  function automatic logic [7:0] facing_level();
    longint unsigned ax, ay, az, s, rhs, t;
    logic [7:0] k;
    ax = nrm_acc[0] < 0 ? -nrm_acc[0] : nrm_acc[0];
    ay = nrm_acc[1] < 0 ? -nrm_acc[1] : nrm_acc[1];
    az = nrm_acc[2] < 0 ? -nrm_acc[2] : nrm_acc[2];
    k = 8'd0;
    if (nrm_acc[0] <= 0) return 8'd0;
    while (ax >= 64'd1048576 || ay >= 64'd1048576 || az >= 64'd1048576) begin
      ax >>= 1;
      ay >>= 1;
      az >>= 1;
    end
    if (ax == 0) return 8'd0;
    s = ax * ax + ay * ay + az * az;
    rhs = 64'd65025 * ax * ax;
    for (int b = 7; b >= 0; b--) begin
      t = k | (8'd1 << b);
      if (t * t * s <= rhs) k = t[7:0];
    end
    return k;
  endfunction

  function automatic logic [7:0] add_light(logic [7:0] amb, logic [7:0] lvl);
    return (int'(amb) + int'(lvl) > 255) ? 8'd255 : amb + lvl;
  endfunction

  task automatic skin_vertex(request_t r);
    longint tp, tn, m;
    longint p [3];
    longint n [3];
    logic [7:0] lvl;
    vertex_t v;
    if (r.cmd == CMD_MATRIX) begin
      matrix_writes++;
      if (r.elem < MatWords) begin
        bone_mat[r.bone * MatWords + r.elem] = r.mval;
        bone_written[r.bone][r.elem] = 1'b1;
        if (&bone_written[r.bone] && !(r.bone inside {ready_bones}))
          ready_bones.push_back(r.bone);
      end
      return;
    end
    influences++;
    p[0] = r.px; p[1] = r.py; p[2] = r.pz;
    n[0] = r.nx; n[1] = r.ny; n[2] = r.nz;
    for (int row = 0; row < 3; row++) begin
      tp = bone_mat[r.bone * MatWords + row * 4 + 3];
      tn = 0;
      for (int c = 0; c < 3; c++) begin
        m = bone_mat[r.bone * MatWords + row * 4 + c];
        tp += (m * p[c]) >>> FracBits;
        tn += (m * n[c]) >>> FracBits;
      end
      tp = clip32(tp);
      tn = clip32(tn);
      pos_acc[row] = clip48(pos_acc[row] + ((tp * longint'(r.w)) >>> 16));
      nrm_acc[row] = clip32(nrm_acc[row] + ((tn * longint'(r.w)) >>> 16));
    end
    if (!r.last) return;
    lvl = facing_level();
    v.x = 32'(clip32(pos_acc[0]));
    v.y = 32'(clip32(pos_acc[1]));
    v.z = 32'(clip32(pos_acc[2]));
    v.red = add_light(amb_r, lvl);
    v.green = add_light(amb_g, lvl);
    v.blue = add_light(amb_b, lvl);
    pending_vertices.push_back(v);
    for (int i = 0; i < 3; i++) begin
      pos_acc[i] = 0;
      nrm_acc[i] = 0;
    end
  endtask

  // one request, sometimes followed by a random gap unless the run is quiet
  task automatic send_request(request_t r);
    in_valid <= 1'b1;
    in_command <= r.cmd;
    in_bone <= r.bone;
    in_element <= r.elem;
    in_matrix_value <= r.mval;
    in_pos_x <= r.px;
    in_pos_y <= r.py;
    in_pos_z <= r.pz;
    in_norm_x <= r.nx;
    in_norm_y <= r.ny;
    in_norm_z <= r.nz;
    in_weight <= r.w;
    in_last_influence <= r.last;
    do @(posedge clk); while (!in_ready);
    skin_vertex(r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_ambient(logic [1:0] idx, logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_AMB_RED:   amb_r = val;
      REG_AMB_GREEN: amb_g = val;
      default:       amb_b = val;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_ambient(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    wait_drained();
    write_ambient(REG_AMB_RED, r);
    write_ambient(REG_AMB_GREEN, g);
    write_ambient(REG_AMB_BLUE, b);
  endtask

  function automatic logic [31:0] wide_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    endcase
  endfunction

  function automatic logic [31:0] matrix_value();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      3: return 32'h0001_0000;
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic logic [15:0] normal_part();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic request_t matrix_req(int b, int e, logic [31:0] val);
    request_t r;
    r = '0;
    r.cmd = CMD_MATRIX;
    r.bone = 6'(b);
    r.elem = 4'(e);
    r.mval = val;
    r.px = $urandom;
    r.nx = 16'($urandom);
    r.w = 16'($urandom);
    r.last = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic request_t influence_req(int b, logic lst);
    request_t r;
    r.cmd = CMD_INFLUENCE;
    r.bone = 6'(b);
    r.elem = 4'($urandom);
    r.mval = $urandom;
    r.px = wide_value();
    r.py = wide_value();
    r.pz = wide_value();
    r.nx = normal_part();
    r.ny = normal_part();
    r.nz = normal_part();
    case ($urandom_range(0, 9))
      0: r.w = 16'h0000;
      1: r.w = 16'hFFFF;
      default: r.w = 16'($urandom);
    endcase
    r.last = lst;
    return r;
  endfunction

  task automatic send_vertex();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      send_request(influence_req(ready_bones[$urandom_range(0, ready_bones.size() - 1)],
                                 i == n - 1));
  endtask

  task automatic random_mix(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(matrix_req($urandom_range(0, 63), $urandom_range(0, 15),
                                matrix_value()));
        sent++;
      end else begin
        send_vertex();
        sent += 2;
      end
    end
  endtask

  task automatic test_matrix_load();
    int bones [$];
    bones = '{0, 63, 62, 21, 42};
    for (int i = 0; i < 6; i++) bones.push_back($urandom_range(1, 61));
    foreach (bones[i])
      for (int e = 0; e < MatWords; e++) begin
        if (bones[i] == 0)
          send_request(matrix_req(0, e, (e % 5 == 0) ? 32'h0001_0000 : 32'h0));
        else if (bones[i] == 62)
          send_request(matrix_req(62, e, e[0] ? 32'h8000_0000 : 32'h7FFF_FFFF));
        else
          send_request(matrix_req(bones[i], e, matrix_value()));
      end
  endtask

  task automatic test_directed();
    request_t r;
    // out of range elements leave the store alone
    for (int e = MatWords; e < 16; e++) send_request(matrix_req(0, e, $urandom));
    // identity bone, extremes of position and normal, full weight
    r = influence_req(0, 1'b1);
    r.px = 32'h7FFF_FFFF; r.py = 32'h8000_0000; r.pz = 32'h0;
    r.nx = 16'h7FFF; r.ny = 16'h0; r.nz = 16'h0; r.w = 16'hFFFF;
    send_request(r);
    // backward normal
    r.px = 32'h8000_0000; r.nx = 16'h8000; r.ny = 16'h7FFF;
    send_request(r);
    // zero normal
    r.nx = 16'h0; r.ny = 16'h0; r.nz = 16'h0; r.w = 16'h8000;
    send_request(r);
    // zero weight
    r = influence_req(63, 1'b1);
    r.w = 16'h0;
    send_request(r);
    // saturating bone, many full weight influences
    for (int i = 0; i < 8; i++) begin
      r = influence_req(62, i == 7);
      r.px = 32'h7FFF_FFFF; r.py = 32'h8000_0000; r.pz = 32'h7FFF_FFFF;
      r.nx = 16'h7FFF; r.ny = 16'h8000; r.nz = 16'h7FFF; r.w = 16'hFFFF;
      send_request(r);
    end
    for (int i = 0; i < 3; i++) send_request(influence_req(63, i == 2));
  endtask

  task automatic test_ambient_extremes();
    set_ambient(8'd0, 8'd0, 8'd0);
    random_mix(40);
    set_ambient(8'd255, 8'd255, 8'd255);
    random_mix(40);
    set_ambient(8'd255, 8'd0, 8'd128);
    random_mix(40);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      set_ambient(8'($urandom), 8'($urandom), 8'($urandom));
      random_mix(120);
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_start = 1'b1;
    quiet = 1'b1;
    repeat (40) send_vertex();
    quiet = 1'b0;
    end_burst();
  endtask

  task automatic test_drain_pause();
    random_mix(60);
    wait_drained();
    random_mix(60);
  endtask

  task automatic test_no_idle();
    wait_drained();
    quiet = 1'b1;
    random_mix(100);
  endtask

  // receiver: random stall bursts plus one long hold on request
  always @(posedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      long_hold = 400;
    end
    if (long_hold > 0) begin
      long_hold--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    vertex_t got, want;
    got = {out_out_x, out_out_y, out_out_z, out_color_red, out_color_green, out_color_blue};
    if (rst_n && out_valid && out_ready) begin
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex %p", got);
      end else begin
        want = pending_vertices.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("vertex mismatch: expected xyz %0d %0d %0d rgb %0d %0d %0d,%s",
                     want.x, want.y, want.z, want.red, want.green, want.blue,
                     $sformatf(" got xyz %0d %0d %0d rgb %0d %0d %0d",
                               got.x, got.y, got.z, got.red, got.green, got.blue));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 800000) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    foreach (bone_written[i]) bone_written[i] = '0;
    foreach (bone_mat[i]) bone_mat[i] = 0;
    for (int i = 0; i < 3; i++) begin
      pos_acc[i] = 0;
      nrm_acc[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_matrix_load();
    test_directed();
    test_ambient_extremes();
    test_random();
    test_backpressure();
    test_drain_pause();
    test_no_idle();
    wait_drained();
    if (pending_vertices.size() != 0) errors++;
    $display("covered %0d matrix writes, %0d influences, %0d lit vertices checked",
             matrix_writes, influences, vertices_seen);
    $display("ambient extremes, saturation, zero and backward normals, long output stall");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/svl_pkg.sv
hdl/svl_isqrt_div.sv
hdl/skinned_vertex_lighting.sv
tb/testbench.sv
